// ===== rtl/tcp_transfer_time_estimator_top_assert.svh =====
// Assertion macros used by the estimator top.
`ifndef TCP_TRANSFER_TIME_ESTIMATOR_TOP_ASSERT_SVH
`define TCP_TRANSFER_TIME_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MSS    = 3'd0;
    localparam logic [2:0] CFG_WINDOW = 3'd1;
    localparam logic [2:0] CFG_RTT    = 3'd2;
    localparam logic [2:0] CFG_BW     = 3'd3;
    localparam logic [2:0] CFG_LOSS   = 3'd4;

    localparam int CfgWidth = 40;

    // Reset values of the configuration registers.
    localparam logic [15:0] MSS_RESET    = 16'd1460;
    localparam logic [31:0] WINDOW_RESET = 32'd65535;
    localparam logic [15:0] RTT_RESET    = 16'd100;
    localparam logic [39:0] BW_RESET     = 40'd1000000000;
    localparam logic [19:0] LOSS_RESET   = 20'd0;

    // Arithmetic constants.
    localparam logic [12:0] BITS_PER_KB  = 13'd8000;
    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS    = 20'd1000000;
    localparam logic [63:0] SQRT_NUM_Q32 = 64'd1500000 << 32;

    // Precomputed link figures handed to the item pipeline.
    typedef struct packed {
        logic        busy;
        logic [39:0] tp;
        logic [35:0] rtt_ns;
        logic [15:0] mss;
    } rate_t;

endpackage

`default_nettype wire

// ===== rtl/tte_rate_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tte_rate_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [tte_pkg::CfgWidth-1:0]  cfg_data,
    output tte_pkg::rate_t                     rate
);

    typedef enum logic [3:0] {
        ST_START, ST_WDIV, ST_RATIO, ST_RDIV, ST_SQINIT,
        ST_SQRT, ST_MUL1, ST_MUL2, ST_MDIV, ST_FIN, ST_DONE
    } state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] mss_reg;
    logic [31:0] window_reg;
    logic [15:0] rtt_reg;
    logic [39:0] bw_reg;
    logic [19:0] loss_reg;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] sx_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] prod_reg;
    logic [39:0] tp_reg;
    logic [35:0] rtt_ns_reg;

    logic [15:0] mss_eff;
    logic [39:0] bw_eff;
    logic [32:0] div_r;
    logic        div_ge;
    logic [31:0] rem_next;
    logic [63:0] quo_next;
    logic [63:0] sq_sum;

    assign mss_eff = (mss_reg == 16'd0) ? 16'd1 : mss_reg;
    assign bw_eff  = (bw_reg == 40'd0) ? 40'd1 : bw_reg;

    // One restoring division step: one quotient bit per cycle.
    assign div_r    = {rem_reg, num_reg[63]};
    assign div_ge   = div_r >= {1'b0, den_reg};
    assign rem_next = div_ge ? 32'(div_r - {1'b0, den_reg}) : div_r[31:0];
    assign quo_next = {quo_reg[62:0], div_ge};

    // Candidate of one digit-by-digit square root step.
    assign sq_sum = res_reg + bit_reg;

    // Sequencer: recomputes throughput and rtt after reset and each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            cnt_reg    <= '0;
            mss_reg    <= tte_pkg::MSS_RESET;
            window_reg <= tte_pkg::WINDOW_RESET;
            rtt_reg    <= tte_pkg::RTT_RESET;
            bw_reg     <= tte_pkg::BW_RESET;
            loss_reg   <= tte_pkg::LOSS_RESET;
        end
        else if (cfg_we)
        begin
            state_reg <= ST_START;
            unique case (cfg_index)
                tte_pkg::CFG_MSS:    mss_reg    <= cfg_data[15:0];
                tte_pkg::CFG_WINDOW: window_reg <= cfg_data[31:0];
                tte_pkg::CFG_RTT:    rtt_reg    <= cfg_data[15:0];
                tte_pkg::CFG_BW:     bw_reg     <= cfg_data[39:0];
                tte_pkg::CFG_LOSS:   loss_reg   <= cfg_data[19:0];
                default:             ;
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_START:
                begin
                    rtt_ns_reg <= 36'(rtt_reg) * 36'(tte_pkg::NS_PER_MS);
                    if (rtt_reg == 16'd0)
                    begin
                        tp_reg    <= bw_eff;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        num_reg   <= 64'(window_reg) * 64'(tte_pkg::BITS_PER_KB);
                        den_reg   <= {16'd0, rtt_reg};
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_WDIV;
                    end
                end
                ST_WDIV, ST_RDIV, ST_MDIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    num_reg <= {num_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        if (state_reg == ST_WDIV)
                        begin
                            state_reg <= ST_RATIO;
                        end
                        else if (state_reg == ST_RDIV)
                        begin
                            state_reg <= ST_SQINIT;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_RATIO:
                begin
                    tp_reg <= (quo_reg < {24'd0, bw_eff}) ? quo_reg[39:0] : bw_eff;
                    if (loss_reg == 20'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        num_reg   <= tte_pkg::SQRT_NUM_Q32;
                        den_reg   <= {12'd0, loss_reg};
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_RDIV;
                    end
                end
                ST_SQINIT:
                begin
                    sx_reg    <= quo_reg;
                    res_reg   <= '0;
                    bit_reg   <= 64'd1 << 62;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sx_reg >= sq_sum)
                    begin
                        sx_reg  <= sx_reg - sq_sum;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    prod_reg  <= 64'(res_reg[31:0]) * 64'(tte_pkg::BITS_PER_KB);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    num_reg   <= 64'(prod_reg[44:0]) * 64'(mss_eff);
                    den_reg   <= {rtt_reg, 16'd0};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MDIV;
                end
                ST_FIN:
                begin
                    if (quo_reg < {24'd0, tp_reg})
                    begin
                        tp_reg <= quo_reg[39:0];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    state_reg <= ST_DONE;
                end
                default:
                begin
                    state_reg <= ST_START;
                end
            endcase
        end
    end

    assign rate.busy   = (state_reg != ST_DONE);
    assign rate.tp     = tp_reg;
    assign rate.rtt_ns = rtt_ns_reg;
    assign rate.mss    = mss_eff;

endmodule

`default_nettype wire

// ===== rtl/tcp_transfer_time_estimator_top.sv =====
// Estimates the receive time in ns of a message of n_bytes bytes over a TCP
// link. The link figures (throughput capped by window, bandwidth and loss,
// and the round trip in ns) are recomputed by a serial sequencer after reset
// and after every configuration write (a shorter sequence without loss or with a zero
// round trip), during which in_stall is high. After that one item is accepted per
// cycle while the output is not stalled. The pipeline holds two pipelined restoring
// dividers, 32 stages for the packet count and 64 stages for the time quotient.
// An output stall holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_transfer_time_estimator_top_assert.svh"

module tcp_transfer_time_estimator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [tte_pkg::CfgWidth-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [31:0]                   n_bytes,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [63:0]                        recv_time_ns
);

    tte_pkg::rate_t rate;

    tte_rate_unit u_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rate      (rate)
    );

    logic adv;
    logic accept;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = rate.busy || !adv;
    assign accept   = in_valid && !in_stall;

    // Packet count divider: one quotient bit per stage.
    logic [31:0] pk_n_reg   [0:32];
    logic [15:0] pk_rem_reg [0:32];
    logic [31:0] pk_q_reg   [0:32];
    logic        pk_v_reg   [0:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            pk_v_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pk_n_reg[0]   <= n_bytes;
            pk_rem_reg[0] <= '0;
            pk_q_reg[0]   <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < 32; k++)
        begin : g_pk
            logic [16:0] r_next;
            logic        ge_next;

            assign r_next  = {pk_rem_reg[k], pk_n_reg[k][31-k]};
            assign ge_next = r_next >= {1'b0, rate.mss};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pk_v_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    pk_v_reg[k+1] <= pk_v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pk_n_reg[k+1]   <= pk_n_reg[k];
                    pk_rem_reg[k+1] <= ge_next ? 16'(r_next - {1'b0, rate.mss})
                                               : r_next[15:0];
                    pk_q_reg[k+1]   <= {pk_q_reg[k][30:0], ge_next};
                end
            end
        end
    endgenerate

    // Wire bits including headers.
    logic [32:0] pkts_next;
    logic [40:0] bits_next;
    logic [40:0] bits_reg;
    logic        bits_v_reg;

    assign pkts_next = {1'b0, pk_q_reg[32]} + {32'd0, (pk_rem_reg[32] != 16'd0)};
    assign bits_next = {3'd0, 38'({6'd0, pk_n_reg[32]} + {5'd0, pkts_next} * 38'd40)} << 3;

    // Scaling to ns: product split in two partial products.
    logic [61:0] mlo_reg;
    logic [38:0] mhi_reg;
    logic        mul_v_reg;
    logic [70:0] prod_next;
    logic [70:0] prod_reg;
    logic        prod_v_reg;
    logic        sat_next;

    assign prod_next = {9'd0, mlo_reg} + ({32'd0, mhi_reg} << 32);
    assign sat_next  = (rate.tp == 40'd0) || ({33'd0, prod_next[70:64]} >= rate.tp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_v_reg <= 1'b0;
            mul_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            bits_v_reg <= pk_v_reg[32];
            mul_v_reg  <= bits_v_reg;
            prod_v_reg <= mul_v_reg;
        end
    end

    // Time quotient divider: one quotient bit per stage.
    logic [63:0] tq_lo_reg  [0:64];
    logic [39:0] tq_rem_reg [0:64];
    logic [63:0] tq_q_reg   [0:64];
    logic        tq_sat_reg [0:64];
    logic        tq_v_reg   [0:64];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bits_reg      <= bits_next;
            mlo_reg       <= bits_reg[31:0] * tte_pkg::NS_PER_S;
            mhi_reg       <= bits_reg[40:32] * tte_pkg::NS_PER_S;
            prod_reg      <= prod_next;
            tq_lo_reg[0]  <= prod_next[63:0];
            tq_rem_reg[0] <= {33'd0, prod_next[70:64]};
            tq_q_reg[0]   <= '0;
            tq_sat_reg[0] <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            tq_v_reg[0] <= mul_v_reg;
        end
    end

    generate
        for (k = 0; k < 64; k++)
        begin : g_tq
            logic [40:0] r_next;
            logic        ge_next;

            assign r_next  = {tq_rem_reg[k], tq_lo_reg[k][63-k]};
            assign ge_next = r_next >= {1'b0, rate.tp};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tq_v_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    tq_v_reg[k+1] <= tq_v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tq_lo_reg[k+1]  <= tq_lo_reg[k];
                    tq_rem_reg[k+1] <= ge_next ? 40'(r_next - {1'b0, rate.tp})
                                               : r_next[39:0];
                    tq_q_reg[k+1]   <= {tq_q_reg[k][62:0], ge_next};
                    tq_sat_reg[k+1] <= tq_sat_reg[k];
                end
            end
        end
    endgenerate

    // Add the round trip, saturating.
    logic [64:0] sum_next;
    logic        out_sat_next;
    logic        out_valid_reg;
    logic [63:0] out_time_reg;

    assign sum_next     = {1'b0, tq_q_reg[64]} + {29'd0, rate.rtt_ns};
    assign out_sat_next = tq_sat_reg[64] || sum_next[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tq_v_reg[64];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_time_reg <= out_sat_next ? '1 : sum_next[63:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign recv_time_ns = out_time_reg;

    // Checks on pipeline movement, saturation and the divider input.
    `TTE_ASSERT_NEXT(a_hold_valid, !adv, $stable(pk_v_reg[32]) && $stable(tq_v_reg[64]), "pipeline moved while held")
    `TTE_ASSERT_NEXT(a_enter, accept, pk_v_reg[0], "accepted item did not enter the pipeline")
    `TTE_ASSERT_NEXT(a_sat, adv && tq_v_reg[64] && tq_sat_reg[64], recv_time_ns == 64'hFFFF_FFFF_FFFF_FFFF, "saturated item not at maximum")
    `TTE_ASSERT_NOW(a_prod, prod_v_reg, prod_reg[63:0] == tq_lo_reg[0], "product and divider input differ")

endmodule

`default_nettype wire

// ===== tb/tcp_transfer_time_estimator_top_test.sv =====
`timescale 1ns / 1ps

module tcp_transfer_time_estimator_top_test;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 110;
    localparam logic [63:0] TimeMax = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [2:0]                   cfg_index = tte_pkg::CFG_MSS;
    logic [tte_pkg::CfgWidth-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [31:0]                  n_bytes = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [63:0]                  recv_time_ns;

    // Link settings as the block should currently hold them.
    logic [15:0] link_mss = tte_pkg::MSS_RESET;
    logic [31:0] link_window = tte_pkg::WINDOW_RESET;
    logic [15:0] link_rtt = tte_pkg::RTT_RESET;
    logic [39:0] link_bw = tte_pkg::BW_RESET;
    logic [19:0] link_loss = tte_pkg::LOSS_RESET;

    logic [31:0] pending_lengths[$];
    logic [63:0] expected_times[$];
    int          failures = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_percent = 0;

    tcp_transfer_time_estimator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .n_bytes      (n_bytes),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .recv_time_ns (recv_time_ns)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Integer square root, digit by digit.
    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bit_pos;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > x)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (x >= root + bit_pos)
            begin
                x = x - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end
            else
            begin
                root = root >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return root;
    endfunction

    // Receive time of a message under the current link settings.
    function automatic logic [63:0] transfer_time_ns(input logic [31:0] length);
        logic [63:0]  mss;
        logic [63:0]  packets;
        logic [63:0]  wire_bits;
        logic [63:0]  rate;
        logic [63:0]  window_rate;
        logic [63:0]  loss_factor;
        logic [63:0]  loss_rate;
        logic [127:0] quotient;
        logic [127:0] total;
        mss = (link_mss == 0) ? 64'd1 : 64'(link_mss);
        rate = (link_bw == 0) ? 64'd1 : 64'(link_bw);
        packets = (64'(length) + mss - 1) / mss;
        wire_bits = 8 * (64'(length) + 40 * packets);
        if (link_rtt != 0)
        begin
            window_rate = (64'd8000 * 64'(link_window)) / 64'(link_rtt);
            if (window_rate < rate)
                rate = window_rate;
            if (link_loss != 0)
            begin
                loss_factor = int_sqrt((64'd1500000 << 32) / 64'(link_loss));
                loss_rate = (loss_factor * 64'd8000 * mss) / (64'(link_rtt) << 16);
                if (loss_rate < rate)
                    rate = loss_rate;
            end
        end
        if (rate == 0)
            return TimeMax;
        quotient = (128'(wire_bits) * 128'd1000000000) / 128'(rate);
        total = quotient + 128'(link_rtt) * 128'd1000000;
        return (total > 128'(TimeMax)) ? TimeMax : total[63:0];
    endfunction

    // Register write; the expected settings follow the write.
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[tte_pkg::CfgWidth-1:0];
        case (index)
            tte_pkg::CFG_MSS:    link_mss = value[15:0];
            tte_pkg::CFG_WINDOW: link_window = value[31:0];
            tte_pkg::CFG_RTT:    link_rtt = value[15:0];
            tte_pkg::CFG_BW:     link_bw = value[39:0];
            tte_pkg::CFG_LOSS:   link_loss = value[19:0];
            default:             ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_link(input logic [15:0] mss, input logic [31:0] window,
                              input logic [15:0] rtt, input logic [39:0] bw,
                              input logic [19:0] loss);
        write_reg(tte_pkg::CFG_MSS, 64'(mss));
        write_reg(tte_pkg::CFG_WINDOW, 64'(window));
        write_reg(tte_pkg::CFG_RTT, 64'(rtt));
        write_reg(tte_pkg::CFG_BW, 64'(bw));
        write_reg(tte_pkg::CFG_LOSS, 64'(loss));
    endtask

    // Waits until every queued item is sent and every expected result is back, then
    // lets the pipeline settle before settings may change.
    task automatic drain;
        wait (pending_lengths.size() == 0 && !in_valid && expected_times.size() == 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Random message lengths: full range, up to 100000, near packet boundaries, short.
    task automatic queue_random(input int count);
        int          pick;
        logic [31:0] mss;
        mss = (link_mss == 0) ? 32'd1 : 32'(link_mss);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                pending_lengths.push_back($urandom);
            else if (pick < 6)
                pending_lengths.push_back($urandom_range(0, 100000));
            else if (pick < 8)
                pending_lengths.push_back(mss * $urandom_range(0, 50) + $urandom_range(0, 2) - 1);
            else
                pending_lengths.push_back($urandom_range(0, 64));
        end
    endtask

    // Stimulus: directed corners, then phases of random settings.
    initial
    begin
        logic [19:0] loss;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Default settings with extreme and boundary lengths.
        stall_percent = 0;
        pending_lengths = '{32'd0, 32'd1, 32'd1459, 32'd1460, 32'd1461, 32'd2920,
                            32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'd65535, 32'd1000000};
        drain();

        // Zero round trip: throughput is the bandwidth alone.
        write_link(16'd1, 32'hFFFF_FFFF, 16'd0, 40'hFF_FFFF_FFFF, 20'd0);
        pending_lengths = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd12345};
        drain();

        // Largest mss, round trip and loss (above one million), window of one, one bit per second.
        write_link(16'hFFFF, 32'd1, 16'hFFFF, 40'd1, 20'hFFFFF);
        pending_lengths = '{32'd0, 32'd65535, 32'hFFFF_FFFF};
        drain();

        // Zero mss, zero bandwidth, zero window: zero throughput.
        write_link(16'd0, 32'd0, 16'd5, 40'd0, 20'd1);
        pending_lengths = '{32'd0, 32'd7, 32'hFFFF_FFFF};
        drain();

        // Tiny loss and a short round trip.
        write_link(16'd1460, 32'hFFFF_FFFF, 16'd1, 40'hFF_FFFF_FFFF, 20'd1);
        pending_lengths = '{32'd0, 32'd1460, 32'hFFFF_FFFF};
        drain();

        // Random phases under a mix of receiver stall rates.
        for (int phase = 0; phase < 12; phase++)
        begin
            loss = ($urandom_range(0, 2) == 0) ? 20'd0 : 20'($urandom_range(1, 1048575));
            write_link(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 9000)),
                       ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1000, 4000000),
                       ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)),
                       ($urandom_range(0, 2) == 0) ? {8'($urandom), 32'($urandom)}
                                                   : 40'($urandom_range(1, 2000000000)),
                       loss);
            stall_percent = (phase % 4) * 25;
            queue_random(50);
            drain();
            queue_random(50);
            drain();
        end

        if (failures == 0)
            $display("tcp_transfer_time_estimator_top_test: PASS");
        else
            $display("tcp_transfer_time_estimator_top_test: FAIL");
        $finish;
    end

    // Sender: bursts of items with random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_lengths.size() != 0)
            begin
                in_valid <= 1'b1;
                n_bytes <= pending_lengths.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_percent);
    end

    // Predict on each accepted item and check each accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_times.push_back(transfer_time_ns(n_bytes));
            if (out_valid && !out_stall)
            begin
                if (expected_times.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, recv_time_ns);
                    failures++;
                end
                else if (expected_times[0] !== recv_time_ns)
                begin
                    $display("%0t: recv_time_ns mismatch, expected %0d, actual %0d",
                             $time, expected_times[0], recv_time_ns);
                    failures++;
                    void'(expected_times.pop_front());
                end
                else
                begin
                    void'(expected_times.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tcp_transfer_time_estimator_top_test: FAIL");
            $finish;
        end
    end

endmodule
